>>> rtl/core/csa_pkg.sv
// Shared constants, state type and controller/datapath command and status types.
package csa_pkg;

    localparam int ELEM_W  = 16;
    localparam int ACC_W   = 48;
    localparam int MAX_DIM = 1024;
    localparam int DIM_W   = $clog2(MAX_DIM + 2);
    localparam int Q_W     = 16;
    localparam int FRAC    = 30;
    localparam int PROD_W  = 2 * ACC_W;
    localparam int CMP_W   = PROD_W + 32;
    localparam int SEQ_W   = $clog2(ACC_W);
    localparam int PP_W    = 2 * ELEM_W;

    typedef enum logic [2:0] {
        S_ACC,
        S_LOAD,
        S_MUL,
        S_INIT,
        S_CAND,
        S_UPD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic acc;
        logic load;
        logic mul;
        logic rinit;
        logic rcand;
        logic rupd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic special;
    } t_sts;

endpackage

>>> rtl/core/csa_if.sv
// Valid/ready stream interfaces for the element-pair input and the result output.
interface csa_in_if
    import csa_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last;

    modport source (output valid, output elem_a, output elem_b, output last, input ready);
    modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface csa_out_if
    import csa_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] similarity;
    logic                     zero_norm;
    logic                     too_long;

    modport source (output valid, output similarity, output zero_norm, output too_long,
                    input ready);
    modport sink   (input valid, input similarity, input zero_norm, input too_long,
                    output ready);
endinterface

>>> rtl/core/csa_ctrl.sv
// Sequencer: accumulate, multiply, bit-by-bit root search, result hand-off.
module csa_ctrl
    import csa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid
);

    t_state             r_state, n_state;
    logic [SEQ_W-1:0]   r_cnt, n_cnt;
    logic               r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_ACC: begin
                o_cmd.acc = i_in_valid;
                if (i_in_valid && i_in_last) n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = i_sts.special ? S_FIN : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == SEQ_W'(ACC_W - 1)) n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.rinit = 1'b1;
                n_cnt       = '0;
                n_state     = S_CAND;
            end
            S_CAND: begin
                o_cmd.rcand = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                o_cmd.rupd = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                n_state    = (r_cnt == SEQ_W'(Q_W - 1)) ? S_FIN : S_CAND;
            end
            S_FIN: begin
                // wait for the output register to drain
                if (!r_ov || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (o_cmd.emit)             n_ov = 1'b1;
        else if (r_ov && i_out_ready) n_ov = 1'b0;
    end

    assign o_in_ready  = (r_state == S_ACC);
    assign o_out_valid = r_ov;

endmodule

>>> rtl/core/csa_dp.sv
// Datapath: accumulators, shift-add multipliers, root search and result register.
module csa_dp
    import csa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic signed [ELEM_W-1:0] i_elem_a,
    input  logic signed [ELEM_W-1:0] i_elem_b,
    output t_sts                     o_sts,
    output logic signed [ELEM_W-1:0] o_similarity,
    output logic                     o_zero_norm,
    output logic                     o_too_long
);

    logic signed [ACC_W-1:0] r_dot;
    logic [ACC_W-1:0]        r_na, r_nb;
    logic [DIM_W-1:0]        r_dim;

    logic [PROD_W-1:0]       r_mc_n, r_mc_d, r_pn, r_pd;
    logic [ACC_W-1:0]        r_mp_n, r_mp_d;

    logic [CMP_W-1:0]        r_p, r_qs, r_ns, r_r, r_cand;
    logic [Q_W-1:0]          r_q;
    logic                    r_neg, r_zero, r_long;

    logic signed [ELEM_W-1:0] r_sim_o;
    logic                     r_zero_o, r_long_o;

    logic signed [PP_W-1:0]  w_ab, w_aa, w_bb;
    logic [ACC_W-1:0]        w_dmag;
    logic                    w_long, w_zero, w_take;
    logic [CMP_W-1:0]        w_qs_sum;
    logic signed [ELEM_W-1:0] w_sim;

    assign w_ab   = i_elem_a * i_elem_b;
    assign w_aa   = i_elem_a * i_elem_a;
    assign w_bb   = i_elem_b * i_elem_b;
    assign w_dmag = r_dot[ACC_W-1] ? ACC_W'(-r_dot) : ACC_W'(r_dot);
    assign w_long = (r_dim > DIM_W'(MAX_DIM));
    assign w_zero = (r_na == '0) || (r_nb == '0);
    assign o_sts.special = w_long || w_zero;

    assign w_take   = (r_cand <= r_r);
    assign w_qs_sum = r_qs + (w_take ? (r_ns << 1) : '0);

    always_comb begin
        if (r_long || r_zero)                 w_sim = '0;
        else if (r_neg)                       w_sim = r_q[Q_W-1] ? ELEM_W'(16'sh8000)
                                                                 : -$signed(r_q);
        else if (r_q[Q_W-1])                  w_sim = ELEM_W'(16'sh7fff);
        else                                  w_sim = $signed(r_q);
    end

    // accumulators are architectural state, cleared on reset and after each vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_dim <= '0;
        end else if (i_cmd.load) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_dim <= '0;
        end else if (i_cmd.acc) begin
            if (r_dim < DIM_W'(MAX_DIM)) begin
                r_dot <= r_dot + ACC_W'(w_ab);
                r_na  <= r_na + ACC_W'(unsigned'(w_aa));
                r_nb  <= r_nb + ACC_W'(unsigned'(w_bb));
            end
            if (r_dim <= DIM_W'(MAX_DIM)) r_dim <= r_dim + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_long <= w_long;
            r_zero <= !w_long && w_zero;
            r_neg  <= r_dot[ACC_W-1];
            r_q    <= '0;
            r_mc_n <= PROD_W'(r_na);
            r_mp_n <= r_nb;
            r_mc_d <= PROD_W'(w_dmag);
            r_mp_d <= w_dmag;
            r_pn   <= '0;
            r_pd   <= '0;
        end
        if (i_cmd.mul) begin
            if (r_mp_n[0]) r_pn <= r_pn + r_mc_n;
            if (r_mp_d[0]) r_pd <= r_pd + r_mc_d;
            r_mc_n <= r_mc_n << 1;
            r_mc_d <= r_mc_d << 1;
            r_mp_n <= r_mp_n >> 1;
            r_mp_d <= r_mp_d >> 1;
        end
        // P = q^2*N, Qs = q*N << (k+1), Ns = N << 2k for current bit k
        if (i_cmd.rinit) begin
            r_p  <= '0;
            r_qs <= '0;
            r_ns <= CMP_W'(r_pn) << FRAC;
            r_r  <= CMP_W'(r_pd) << FRAC;
            r_q  <= '0;
        end
        if (i_cmd.rcand) r_cand <= r_p + r_qs + r_ns;
        if (i_cmd.rupd) begin
            if (w_take) r_p <= r_cand;
            r_qs <= w_qs_sum >> 1;
            r_ns <= r_ns >> 2;
            r_q  <= {r_q[Q_W-2:0], w_take};
        end
        if (i_cmd.emit) begin
            r_sim_o  <= w_sim;
            r_zero_o <= r_zero;
            r_long_o <= r_long;
        end
    end

    assign o_similarity = r_sim_o;
    assign o_zero_norm  = r_zero_o;
    assign o_too_long   = r_long_o;

endmodule

>>> rtl/core/cosine_similarity_accumulator_unit.sv
// Sequence: after a marked pair the shift-add multipliers run, then the root search
// takes a candidate step and an update step per result bit; zero-norm and too-long
// results skip the multipliers and the root search.
// Throughput: one element pair per cycle within a vector; input stalls from the
// marked pair until its result is registered. Synchronous active-low reset clears
// the accumulators, the sequencer and the output valid.
module cosine_similarity_accumulator_unit
    import csa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    csa_in_if.sink   i_in,
    csa_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    csa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    csa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_elem_a     (i_in.elem_a),
        .i_elem_b     (i_in.elem_b),
        .o_sts        (w_sts),
        .o_similarity (o_out.similarity),
        .o_zero_norm  (o_out.zero_norm),
        .o_too_long   (o_out.too_long)
    );

endmodule

>>> rtl/core/csa_checker.sv
// Port-level assertions for the cosine similarity unit, bound to the top level.
module csa_checker
    import csa_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_last,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [ELEM_W-1:0] i_similarity,
    input logic              i_zero_norm,
    input logic              i_too_long
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_similarity))
        else $error("result dropped or changed while stalled");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_zero_norm && i_too_long))
        else $error("zero_norm and too_long both set");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_zero_norm || i_too_long) |-> i_similarity == '0)
        else $error("flagged result with nonzero similarity");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input taken during result computation");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind cosine_similarity_accumulator_unit csa_checker u_csa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_last    (i_in.last),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_similarity (o_out.similarity),
    .i_zero_norm  (o_out.zero_norm),
    .i_too_long   (o_out.too_long)
);
